[design/sce_pkg.sv]
// Shared types, constants, sine table, filter coefficients and saturation helpers.
package sce_pkg;

  localparam int DELAY_DEPTH = 4096;
  localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
  localparam int DPOS_W      = DELAY_AW + 8;       // read position, Q.8 samples
  localparam int SAMPLE_W    = 24;
  localparam int SINE_N      = 1024;
  localparam int SINE_AW     = $clog2(SINE_N);
  localparam int PHASE_W     = 24;
  localparam int CFG_DW      = 23;
  localparam int CFG_IW      = 3;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_LFO_STEP = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DEPTH    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BASE     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FB_GAIN  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_WARMTH   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_WIDTH    = 3'd5;

  typedef struct packed {
    logic [22:0] lfo_step;
    logic [19:0] depth;
    logic [11:0] base;
    logic [14:0] fb_gain;
    logic [15:0] warmth;
    logic [15:0] width;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic                take;
    logic                clr_en;
    logic [DELAY_AW-1:0] clr_addr;
  } lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  typedef logic signed [SAMPLE_W-1:0] sine_tab_t [SINE_N];

  // Q23 sine, odd degree-9 polynomial on the quarter wave in Q30
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint q4, quad, rm, t, t2, p, s;
    for (int k = 0; k < SINE_N; k++) begin
      q4   = 4 * longint'(k);
      quad = (q4 / SINE_N) % 4;
      rm   = q4 % SINE_N;
      t    = (rm <<< 30) / SINE_N;
      if (quad % 2 == 1) t = (longint'(1) <<< 30) - t;
      t2 = (t * t) >>> 30;
      p  = 172275;
      p  = -5026995 + ((p * t2) >>> 30);
      p  = 85569306 + ((p * t2) >>> 30);
      p  = -693598669 + ((p * t2) >>> 30);
      p  = 1686629713 + ((p * t2) >>> 30);
      s  = (((p * t) >>> 30) + 64) >>> 7;
      if (s > 8388607) s = 8388607;
      if (s < 0) s = 0;
      tab[k] = SAMPLE_W'((quad >= 2) ? -s : s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Butterworth biquads for 48 kHz, Q30: b0 b1 b2 a1 a2
  localparam logic signed [31:0] LP_COEF [5] = '{
    32'sd166484772, 32'sd332969544, 32'sd166484772, -32'sd665939088, 32'sd258136346};
  localparam logic signed [31:0] HP_COEF [5] = '{
    32'sd1065820339, -32'sd2131640678, 32'sd1065820339, -32'sd2131582237,
    32'sd1057957295};

  localparam logic signed [35:0] SMAX = 36'((longint'(1) <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [35:0] SMIN = -SMAX - 36'sd1;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [35:0] v);
    if (v > SMAX) return SAMPLE_W'(SMAX);
    if (v < SMIN) return SAMPLE_W'(SMIN);
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[design/sce_lane.sv]
// One channel lane: LFO, delay line, biquads, tanh saturation and output mix.
module sce_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                is_right,
  input  sce_pkg::cfg_t                       cfg,
  input  sce_pkg::lane_ctl_t                  ctl,
  input  logic signed [sce_pkg::SAMPLE_W-1:0] x_in,
  input  logic [sce_pkg::DELAY_AW-1:0]        wr_idx,
  output sce_pkg::lane_stat_t                 stat,
  output logic signed [sce_pkg::SAMPLE_W-1:0] y_out
);
  import sce_pkg::*;

  localparam int DSUM_W = DPOS_W + 3;
  localparam logic [DPOS_W-1:0] DMAX = DPOS_W'((DELAY_DEPTH - 1) * 256);
  localparam logic [34:0] UMAX = 35'd5 << 28;
  localparam logic [24:0] TMAX = 25'd1 << 24;
  localparam logic [47:0] PADE_C0 = 48'd135135 << 24;
  localparam logic [4:0]  Q1_TOP = 5'd19;
  localparam logic [4:0]  Q2_TOP = 5'd28;
  localparam logic [PHASE_W-1:0] QUARTER = PHASE_W'(1) << (PHASE_W - 2);

  typedef enum logic [5:0] {
    S_IDLE, S_DEPTH, S_DLY, S_ADDR, S_RD1, S_RD2, S_INTERP, S_MIX, S_FB, S_WR,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5,
    S_ABS, S_CLIP, S_SQ, S_V2, S_SQ2, S_V4, S_CUBE, S_V6, S_PADE, S_DIV1,
    S_SCALE, S_TCLIP, S_DIV2, S_WET, S_SUM, S_RES, S_DONE
  } state_t;

  state_t state;

  logic [PHASE_W-1:0]         phase;
  logic signed [SAMPLE_W-1:0] x, lfo, s1, delayed, res, rd;
  logic [DELAY_AW-1:0]        wi, i1;
  logic [7:0]                 frac;
  logic signed [35:0]         lfk;
  logic [DPOS_W-1:0]          dcl;
  logic signed [21:0]         wp;
  logic signed [31:0]         bq_in, y;
  logic signed [35:0]         acc1, acc2;
  logic                       fsel, neg;
  logic signed [31:0]         m0 [2];
  logic signed [31:0]         m1 [2];
  logic [26:0]                v;
  logic [28:0]                v2;
  logic [33:0]                v4;
  logic [37:0]                v6;
  logic [47:0]                rem1, den;
  logic [19:0]                q1;
  logic [16:0]                rem2;
  logic [28:0]                dd, q2;
  logic [4:0]                 cnt;
  logic signed [29:0]         wet;

  logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] prod;

  // combinational helpers
  logic signed [35:0]       lk;
  logic signed [DSUM_W-1:0] dsum;
  logic [DPOS_W-1:0]        dcl_c, rp;
  logic signed [24:0]       diff;
  logic signed [31:0]       c0, c1, c2, c3, c4, y_c;
  logic signed [33:0]       p30;
  logic [32:0]              a_abs;
  logic [16:0]              g;
  logic [34:0]              ug;
  logic [47:0]              num_c, den_c;
  logic [48:0]              trial1;
  logic [27:0]              t_raw;
  logic [24:0]              t_c;
  logic [17:0]              trial2;
  logic signed [31:0]       sum_c;
  logic                     mem_we;
  logic [DELAY_AW-1:0]      mem_wa, mem_ra;
  logic signed [SAMPLE_W-1:0] mem_wd;

  always_comb begin
    lk   = 36'(lfo) * 36'sd3277;
    dsum = $signed({3'b000, cfg.base, 8'd0}) + DSUM_W'(prod >>> 23);
    if (dsum < 0) begin
      dcl_c = '0;
    end else if (dsum > $signed({3'b000, DMAX})) begin
      dcl_c = DMAX;
    end else begin
      dcl_c = dsum[DPOS_W-1:0];
    end
    rp    = {wi, 8'd0} - dcl;
    diff  = 25'(rd) - 25'(s1);
    c0    = fsel ? HP_COEF[0] : LP_COEF[0];
    c1    = fsel ? HP_COEF[1] : LP_COEF[1];
    c2    = fsel ? HP_COEF[2] : LP_COEF[2];
    c3    = fsel ? HP_COEF[3] : LP_COEF[3];
    c4    = fsel ? HP_COEF[4] : LP_COEF[4];
    p30   = 34'(prod >>> 30);
    y_c   = sat32(36'(p30) + 36'(m0[fsel]));
    a_abs = y[31] ? (33'd0 - {y[31], y}) : {1'b0, y};
    g     = 17'd8192 + 17'(cfg.warmth);
    ug    = prod[47:13];
    num_c = PADE_C0 + 48'(v2) * 48'd17325 + 48'(v4) * 48'd378 + 48'(v6);
    den_c = PADE_C0 + 48'(v2) * 48'd62370 + 48'(v4) * 48'd3150 + 48'(v6) * 48'd28;
    trial1 = (cnt == Q1_TOP) ? {1'b0, rem1} : {rem1, 1'b0};
    t_raw = prod[46:19];
    t_c   = (t_raw > 28'(TMAX)) ? TMAX : t_raw[24:0];
    trial2 = {rem2, dd[28]};
    sum_c = (32'(x) <<< 5) + 32'(wet) + (32'(wp) <<< 5);
  end

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DEPTH:  begin mul_a = 36'(lfo);     mul_b = {16'd0, cfg.depth};   end
      S_DLY:    begin mul_a = lfk;          mul_b = {20'd0, cfg.width};   end
      S_INTERP: begin mul_a = 36'(diff);    mul_b = {28'd0, frac};        end
      S_FB:     begin mul_a = 36'(delayed); mul_b = {21'd0, cfg.fb_gain}; end
      S_B0:     begin mul_a = 36'(c0);      mul_b = 36'(bq_in);           end
      S_B1:     begin mul_a = 36'(c1);      mul_b = 36'(bq_in);           end
      S_B2:     begin mul_a = 36'(c2);      mul_b = 36'(bq_in);           end
      S_B3:     begin mul_a = 36'(c3);      mul_b = 36'(y);               end
      S_B4:     begin mul_a = 36'(c4);      mul_b = 36'(y);               end
      S_ABS:    begin mul_a = {3'd0, a_abs}; mul_b = {19'd0, g};          end
      S_SQ:     begin mul_a = {9'd0, v};    mul_b = {9'd0, v};            end
      S_SQ2:    begin mul_a = {7'd0, v2};   mul_b = {7'd0, v2};           end
      S_CUBE:   begin mul_a = {2'd0, v4};   mul_b = {7'd0, v2};           end
      S_SCALE:  begin mul_a = {9'd0, v};    mul_b = {16'd0, q1};          end
      S_SUM:    begin mul_a = 36'(sum_c);   mul_b = 36'sd22938;           end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // delay line: one write port, one registered read port
  always_comb begin
    mem_we = ctl.clr_en || (state == S_WR);
    mem_wa = ctl.clr_en ? ctl.clr_addr : wi;
    mem_wd = ctl.clr_en ? '0 : sat_sample(36'(x) + 36'(prod >>> 15));
    mem_ra = (state == S_RD2) ? i1 + 1'b1 : i1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= is_right ? QUARTER : '0;
      fsel  <= 1'b0;
      m0    <= '{default: '0};
      m1    <= '{default: '0};
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            x     <= x_in;
            wi    <= wr_idx;
            lfo   <= SINE_TAB[phase[PHASE_W-1 -: SINE_AW]];
            phase <= phase + PHASE_W'(cfg.lfo_step);
            state <= S_DEPTH;
          end
        end
        S_DEPTH: begin
          lfk   <= is_right ? -lk : lk;
          state <= S_DLY;
        end
        S_DLY: begin
          dcl   <= dcl_c;
          state <= S_ADDR;
        end
        S_ADDR: begin
          wp    <= 22'(prod >>> 30);
          i1    <= rp[DPOS_W-1:8];
          frac  <= rp[7:0];
          state <= S_RD1;
        end
        S_RD1:    state <= S_RD2;
        S_RD2: begin
          s1    <= rd;
          state <= S_INTERP;
        end
        S_INTERP: state <= S_MIX;
        S_MIX: begin
          delayed <= SAMPLE_W'(26'(s1) + 26'(prod >>> 8));
          state   <= S_FB;
        end
        S_FB:     state <= S_WR;
        S_WR: begin
          bq_in <= 32'(delayed) <<< 5;
          fsel  <= 1'b0;
          state <= S_B0;
        end
        S_B0:     state <= S_B1;
        S_B1: begin
          y     <= y_c;
          state <= S_B2;
        end
        S_B2: begin
          acc1  <= 36'(p30);
          state <= S_B3;
        end
        S_B3: begin
          acc2  <= 36'(p30);
          state <= S_B4;
        end
        S_B4: begin
          acc1  <= acc1 - 36'(p30);
          state <= S_B5;
        end
        S_B5: begin
          m0[fsel] <= sat32(acc1 + 36'(m1[fsel]));
          m1[fsel] <= sat32(acc2 - 36'(p30));
          if (fsel) begin
            state <= S_ABS;
          end else begin
            fsel  <= 1'b1;
            bq_in <= y;
            state <= S_B0;
          end
        end
        S_ABS: begin
          neg   <= y[31];
          state <= S_CLIP;
        end
        S_CLIP: begin
          v     <= (ug > UMAX) ? 27'(UMAX >> 4) : 27'(ug >> 4);
          state <= S_SQ;
        end
        S_SQ:     state <= S_V2;
        S_V2: begin
          v2    <= prod[52:24];
          state <= S_SQ2;
        end
        S_SQ2:    state <= S_V4;
        S_V4: begin
          v4    <= prod[57:24];
          state <= S_CUBE;
        end
        S_CUBE:   state <= S_V6;
        S_V6: begin
          v6    <= prod[61:24];
          state <= S_PADE;
        end
        S_PADE: begin
          rem1  <= num_c;
          den   <= den_c;
          cnt   <= Q1_TOP;
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (trial1 >= {1'b0, den}) begin
            rem1 <= 48'(trial1 - {1'b0, den});
            q1   <= {q1[18:0], 1'b1};
          end else begin
            rem1 <= trial1[47:0];
            q1   <= {q1[18:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_SCALE;
        end
        S_SCALE:  state <= S_TCLIP;
        S_TCLIP: begin
          rem2  <= {4'd0, t_c[24:12]};
          dd    <= {t_c[11:0], 17'd0};
          cnt   <= Q2_TOP;
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (trial2 >= {1'b0, g}) begin
            rem2 <= 17'(trial2 - {1'b0, g});
            q2   <= {q2[27:0], 1'b1};
          end else begin
            rem2 <= trial2[16:0];
            q2   <= {q2[27:0], 1'b0};
          end
          dd  <= {dd[27:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_WET;
        end
        S_WET: begin
          wet   <= neg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
          state <= S_SUM;
        end
        S_SUM:    state <= S_RES;
        S_RES: begin
          res   <= sat_sample(36'(prod >>> 20));
          state <= S_DONE;
        end
        S_DONE: begin
          if (ctl.take) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign y_out     = res;

endmodule

[design/sce_merge.sv]
// Merge stage: joins both lane results into one output beat register.
module sce_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  sce_pkg::lane_stat_t                 l_stat,
  input  sce_pkg::lane_stat_t                 r_stat,
  input  logic signed [sce_pkg::SAMPLE_W-1:0] l_res,
  input  logic signed [sce_pkg::SAMPLE_W-1:0] r_res,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [sce_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [sce_pkg::SAMPLE_W-1:0] right_out,
  output logic                                take
);
  import sce_pkg::*;

  assign take = l_stat.done && r_stat.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_out  <= l_res;
      right_out <= r_res;
    end
  end

endmodule

[design/stereo_chorus_effect.sv]
// Top level of the stereo chorus: config registers, lanes, clear sweep, output merge.
//
// Stereo chorus on a modulated delay line. Each input beat carries one stereo frame
// of signed Q1.23 samples; each output beat carries the processed frame. Two
// identical lanes, one per channel, run side by side in lockstep, each with its own
// 4096-sample delay memory, LFO phase and biquad state; a merge stage registers
// both results into a single output beat. A lane walks one frame through a sequencer
// around one shared 36x36 multiplier: delay lookup with linear interpolation and
// feedback write-back, an 8 kHz lowpass and an 80 Hz highpass biquad, then the
// Pade tanh saturation, whose two bit-serial dividers (20 and 29 steps) dominate.
// A lane takes no new frame until it has finished the last one and handed its result to
// the merge stage; the next frame is taken while the previous result still waits in
// the output register. After reset the delay memories are swept to zero, one address
// per cycle, which holds in_ready low until the sweep is done; config writes are taken
// at any time but should only be issued while the block is idle.
module stereo_chorus_effect (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sce_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sce_pkg::SAMPLE_W-1:0] right_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sce_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [sce_pkg::SAMPLE_W-1:0] right_out,
  input  logic                                cfg_write,
  input  logic [sce_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [sce_pkg::CFG_DW-1:0]          cfg_data
);
  import sce_pkg::*;

  cfg_t                cfg;
  logic [DELAY_AW:0]   clr_cnt;     // top bit set once the sweep is done
  logic                clearing;
  logic [DELAY_AW-1:0] wr_idx;
  logic                accept;
  logic                take;
  lane_ctl_t           ctl;
  lane_stat_t          l_stat, r_stat;
  logic signed [SAMPLE_W-1:0] l_res, r_res;

  assign clearing = !clr_cnt[DELAY_AW];
  // both lanes must be free; they always move together
  assign in_ready = !clearing && l_stat.idle && r_stat.idle;
  assign accept   = in_valid && in_ready;

  assign ctl.start    = accept;
  assign ctl.take     = take;
  assign ctl.clr_en   = clearing;
  assign ctl.clr_addr = clr_cnt[DELAY_AW-1:0];

  // config registers, out-of-list indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lfo_step <= 23'd350;
      cfg.depth    <= 20'd24576;
      cfg.base     <= 12'd720;
      cfg.fb_gain  <= '0;
      cfg.warmth   <= '0;
      cfg.width    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LFO_STEP: cfg.lfo_step <= cfg_data[22:0];
        REG_DEPTH:    cfg.depth    <= cfg_data[19:0];
        REG_BASE:     cfg.base     <= cfg_data[11:0];
        REG_FB_GAIN:  cfg.fb_gain  <= cfg_data[14:0];
        REG_WARMTH:   cfg.warmth   <= cfg_data[15:0];
        REG_WIDTH:    cfg.width    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // clear sweep after reset, then the shared write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      wr_idx  <= '0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      if (accept)   wr_idx  <= wr_idx + 1'b1;
    end
  end

  sce_lane u_lane_l (
    .clk      (clk),
    .rst      (rst),
    .is_right (1'b0),
    .cfg      (cfg),
    .ctl      (ctl),
    .x_in     (left_in),
    .wr_idx   (wr_idx),
    .stat     (l_stat),
    .y_out    (l_res)
  );

  sce_lane u_lane_r (
    .clk      (clk),
    .rst      (rst),
    .is_right (1'b1),
    .cfg      (cfg),
    .ctl      (ctl),
    .x_in     (right_in),
    .wr_idx   (wr_idx),
    .stat     (r_stat),
    .y_out    (r_res)
  );

  sce_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .l_stat    (l_stat),
    .r_stat    (r_stat),
    .l_res     (l_res),
    .r_res     (r_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .left_out  (left_out),
    .right_out (right_out),
    .take      (take)
  );

`ifndef ASSERT_OFF
  // lanes run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (l_stat.idle == r_stat.idle) && (l_stat.done == r_stat.done))
    else $error("lanes out of step");

  // an accepted frame occupies the lanes
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("frame taken while lanes busy");

  // a finished frame shows up as an output beat
  a_take: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && l_stat.idle)
    else $error("merged beat lost");
`endif

endmodule
